### rtl/i2cds_pkg.sv
// ----------------------------------------------------------------------------
// i2cds_pkg
// Widths, register indexes and the divider-to-code table of the bus clock
// divider selector.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cds_pkg;

  localparam int CLK_W   = 30;
  localparam int SPEED_W = 22;
  localparam int CODE_W  = 6;
  localparam int IDX_W   = 1;

  localparam int TABLE_LEN = 51;
  localparam int NPAIR     = TABLE_LEN - 1;
  localparam int DIV_W     = 16;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BUS_ONE_CLK = 1'd0;
  localparam logic [IDX_W-1:0] REG_BUS_TWO_CLK = 1'd1;

  localparam logic [CODE_W-1:0] CODE_INVALID = 6'h3F;
  localparam logic [CODE_W-1:0] CODE_TOP     = 6'h1F;
  localparam logic [CODE_W-1:0] CODE_LOW     = 6'h20;

  // ascending divider values and the code that goes with each
  localparam logic [DIV_W-1:0] RATE_DIV [TABLE_LEN] = '{
    16'd0,     16'd256,   16'd288,   16'd320,   16'd352,
    16'd384,   16'd416,   16'd448,   16'd480,   16'd512,
    16'd576,   16'd640,   16'd704,   16'd768,   16'd832,
    16'd896,   16'd1024,  16'd1152,  16'd1280,  16'd1536,
    16'd1792,  16'd1920,  16'd2048,  16'd2304,  16'd2560,
    16'd3072,  16'd3584,  16'd3840,  16'd4096,  16'd4608,
    16'd5120,  16'd6144,  16'd7168,  16'd7680,  16'd8192,
    16'd9216,  16'd10240, 16'd12288, 16'd14336, 16'd15360,
    16'd16384, 16'd18432, 16'd20480, 16'd24576, 16'd28672,
    16'd30720, 16'd32768, 16'd36864, 16'd40960, 16'd49152,
    16'd61440
  };

  localparam logic [CODE_W-1:0] RATE_CODE [TABLE_LEN] = '{
    6'h20, 6'h20, 6'h21, 6'h22, 6'h23,
    6'h24, 6'h01, 6'h25, 6'h02, 6'h26,
    6'h27, 6'h28, 6'h05, 6'h29, 6'h06,
    6'h2A, 6'h2B, 6'h08, 6'h2C, 6'h2D,
    6'h2E, 6'h0B, 6'h2F, 6'h0C, 6'h30,
    6'h31, 6'h32, 6'h0F, 6'h33, 6'h10,
    6'h34, 6'h35, 6'h36, 6'h13, 6'h37,
    6'h14, 6'h38, 6'h39, 6'h3A, 6'h17,
    6'h3B, 6'h18, 6'h3C, 6'h3D, 6'h3E,
    6'h1B, 6'h3F, 6'h1C, 6'h1D, 6'h1E,
    6'h1F
  };

endpackage

`default_nettype wire

### rtl/i2c_clock_divider_select.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_select
// Picks the selected bus clock, divides it by the requested speed and maps
// the quotient to the nearest divider code of the rate table.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: speed_hz  tuser: bus_select
//  m_axis    out  tvalid/tready          tdata: rate_code, divide_ratio
//                                        tuser: speed_invalid
//  cfg       in   cfg_we (no wait)       cfg_index, cfg_data
//
//  The pipeline is the input register, 30 restoring divider stages (one
//  quotient bit per stage), two table stages and the output register.
//  One beat per cycle is accepted while the output is drained.
//  A stalled output parks one beat in a skid register; the pipeline then
//  holds and s_axis_tready drops until the skid empties.
//  rst (synchronous) clears valid bits and both clock registers.
//
`default_nettype none

module i2c_clock_divider_select (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [29:0] cfg_data,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [21:0] speed_hz, [23:22] zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] bus_select
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [5:0] rate_code, [35:6] divide_ratio,
                                           // [39:36] zero
  output logic [0:0]       m_axis_tuser    // [0] speed_invalid
);

  localparam int CW = i2cds_pkg::CLK_W;
  localparam int SW = i2cds_pkg::SPEED_W;
  localparam int OW = i2cds_pkg::CODE_W;
  localparam int NP = i2cds_pkg::NPAIR;

  // configuration registers
  logic [CW-1:0] bus_one_clk;
  logic [CW-1:0] bus_two_clk;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_one_clk <= '0;
      bus_two_clk <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cds_pkg::REG_BUS_ONE_CLK: bus_one_clk <= cfg_data;
        i2cds_pkg::REG_BUS_TWO_CLK: bus_two_clk <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the skid register is free
  logic adv;
  logic skid_valid;
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  // divider pipeline: index 0 is the input register, index k+1 after bit k
  logic          dv    [0:CW];
  logic [CW-1:0] dq    [0:CW];
  logic [CW-1:0] ddvd  [0:CW];
  logic [SW-1:0] drem  [0:CW];
  logic [SW-1:0] dsp   [0:CW];
  logic          dinv  [0:CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq[0]   <= '0;
      drem[0] <= '0;
      ddvd[0] <= s_axis_tuser[0] ? bus_two_clk : bus_one_clk;
      dsp[0]  <= s_axis_tdata[SW-1:0];
      dinv[0] <= (s_axis_tdata[SW-1:0] == '0);
    end
  end

  genvar k;
  generate
    for (k = 0; k < CW; k++) begin : g_div
      logic [SW:0] trial;
      logic [SW:0] diff;
      logic        ge;

      // shift in the next dividend bit, subtract if it fits
      assign trial = {drem[k], ddvd[k][CW-1]};
      assign ge    = (trial >= {1'b0, dsp[k]});
      assign diff  = trial - {1'b0, dsp[k]};

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[k+1] <= 1'b0;
        end else if (adv) begin
          dv[k+1] <= dv[k];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          drem[k+1] <= ge ? diff[SW-1:0] : trial[SW-1:0];
          dq[k+1]   <= {dq[k][CW-2:0], ge};
          ddvd[k+1] <= {ddvd[k][CW-2:0], 1'b0};
          dsp[k+1]  <= dsp[k];
          dinv[k+1] <= dinv[k];
        end
      end
    end
  endgenerate

  // table stage 1: per-pair upper-bound and nearer-entry compares
  logic [CW-1:0] ratio_c;
  logic [NP-1:0] le_c;
  logic [NP-1:0] lw_c;

  assign ratio_c = dinv[CW] ? '0 : dq[CW];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      le_c[p] = ratio_c <= CW'(i2cds_pkg::RATE_DIV[p+1]);
      // lower entry wins only when strictly nearer: 2d < lo + hi
      lw_c[p] = {ratio_c, 1'b0} <
                ((CW+1)'(i2cds_pkg::RATE_DIV[p]) + (CW+1)'(i2cds_pkg::RATE_DIV[p+1]));
    end
  end

  logic          t1_v;
  logic [CW-1:0] t1_ratio;
  logic          t1_inv;
  logic [NP-1:0] t1_le;
  logic [NP-1:0] t1_lw;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (adv) begin
      t1_v <= dv[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_ratio <= ratio_c;
      t1_inv   <= dinv[CW];
      t1_le    <= le_c;
      t1_lw    <= lw_c;
    end
  end

  // table stage 2: first bracketing pair decides the code; a zero speed forces the invalid code
  logic [OW-1:0] code_c;

  always_comb begin
    code_c = i2cds_pkg::CODE_TOP;
    for (int p = NP - 1; p >= 0; p--) begin
      if (t1_le[p]) begin
        code_c = t1_lw[p] ? i2cds_pkg::RATE_CODE[p] : i2cds_pkg::RATE_CODE[p+1];
      end
    end
    if (t1_inv) begin
      code_c = i2cds_pkg::CODE_INVALID;
    end
  end

  logic          t2_v;
  logic [OW-1:0] t2_code;
  logic [CW-1:0] t2_ratio;
  logic          t2_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else if (adv) begin
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_code  <= code_c;
      t2_ratio <= t1_ratio;
      t2_inv   <= t1_inv;
    end
  end

  // output register with one skid entry
  logic          out_valid;
  logic [OW-1:0] out_code;
  logic [CW-1:0] out_ratio;
  logic          out_inv;
  logic [OW-1:0] skid_code;
  logic [CW-1:0] skid_ratio;
  logic          skid_inv;
  logic          out_free;
  logic          push;

  assign out_free = !out_valid || m_axis_tready;
  assign push     = adv && t2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid || push;
      end
      if (push && !out_free) begin
        skid_valid <= 1'b1;
      end else if (skid_valid && out_free) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_code  <= skid_code;
        out_ratio <= skid_ratio;
        out_inv   <= skid_inv;
      end else begin
        out_code  <= t2_code;
        out_ratio <= t2_ratio;
        out_inv   <= t2_inv;
      end
    end
    if (push && !out_free) begin
      skid_code  <= t2_code;
      skid_ratio <= t2_ratio;
      skid_inv   <= t2_inv;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_ratio, out_code};
  assign m_axis_tuser  = out_inv;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && skid_valid))
    else $error("input stalled without a blocked output");

  a_invalid_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (out_code == i2cds_pkg::CODE_INVALID && out_ratio == '0))
    else $error("zero speed gave wrong code or ratio");

  a_low_ratio_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0] && out_ratio < CW'(256)) |->
      (out_code == i2cds_pkg::CODE_LOW))
    else $error("ratio below first divider gave wrong code");
`endif

endmodule

`default_nettype wire
